@@ design/sio_pkg.sv @@
`timescale 1ns / 1ps
package sio_pkg;

   localparam int NUM_DEVICES = 11;
   localparam int DEV_W       = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;

   localparam logic [7:0] KEY_RESET    = 8'h87;
   localparam logic [7:0] LOCK_BYTE    = 8'hAA;
   localparam logic [7:0] ID_VALUE     = 8'h97;
   localparam logic [7:0] REV_VALUE    = 8'h73;
   localparam logic [7:0] UNKNOWN_READ = 8'hFF;

   localparam logic [7:0] REG_SEL = 8'h07;
   localparam logic [7:0] REG_ID  = 8'h20;
   localparam logic [7:0] REG_REV = 8'h21;
   localparam logic [7:0] REG_EN  = 8'h30;
   localparam logic [7:0] REG_BHI = 8'h60;
   localparam logic [7:0] REG_BLO = 8'h61;
   localparam logic [7:0] REG_IRQ = 8'h70;
   localparam logic [7:0] REG_DMA = 8'h74;

   // highest device number that triggers a remap (COM2)
   localparam logic [3:0] DEV_LAST_REMAP = 4'd3;

   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;
   localparam logic PORT_INDEX = 1'b0;
   localparam logic PORT_DATA  = 1'b1;

   typedef enum logic {
      ST_LOCKED,
      ST_UNLOCKED
   } lock_state_type;

   typedef struct packed {
      logic load;
      logic rd_index;
      logic rd_reg;
      logic wr_key;
      logic wr_index;
      logic wr_reg;
      logic lock;
      logic unlock;
      logic unlocked;
   } sio_cmd_type;

   typedef struct packed {
      logic lock_byte;
      logic key_hit;
   } sio_status_type;

endpackage

@@ design/sio_req_if.sv @@
`timescale 1ns / 1ps
interface sio_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic       port_sel;
   logic [7:0] write_data;

   modport source (output valid, output func, output port_sel, output write_data,
                   input ready);
   modport sink   (input valid, input func, input port_sel, input write_data,
                   output ready);
endinterface

@@ design/sio_rsp_if.sv @@
`timescale 1ns / 1ps
interface sio_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  read_data;
   logic        regs_unlocked;
   logic        fdc_port_enable;
   logic        reconfig_valid;
   logic [1:0]  reconfig_device;
   logic        reconfig_enabled;
   logic [15:0] reconfig_base;
   logic [7:0]  reconfig_irq;

   modport source (output valid, output read_data, output regs_unlocked,
                   output fdc_port_enable, output reconfig_valid,
                   output reconfig_device, output reconfig_enabled,
                   output reconfig_base, output reconfig_irq, input ready);
   modport sink   (input valid, input read_data, input regs_unlocked,
                   input fdc_port_enable, input reconfig_valid,
                   input reconfig_device, input reconfig_enabled,
                   input reconfig_base, input reconfig_irq, output ready);
endinterface

@@ design/sio_ctrl.sv @@
`timescale 1ns / 1ps
module sio_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_func,
   input  logic                    req_port_sel,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  sio_pkg::sio_status_type status,
   output sio_pkg::sio_cmd_type    cmd
);
   import sio_pkg::*;

   lock_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOCKED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.load     = accept;
      rsp_valid_in = accept ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      if (accept) begin
         case (state_ff)
            ST_LOCKED: begin
               if (req_func == FUNC_WRITE && req_port_sel == PORT_INDEX) begin
                  if (status.lock_byte) begin
                     cmd.lock = 1'b1;
                  end else begin
                     cmd.wr_key = 1'b1;
                     if (status.key_hit) begin
                        cmd.unlock = 1'b1;
                        state_in   = ST_UNLOCKED;
                     end
                  end
               end
            end
            ST_UNLOCKED: begin
               if (req_func == FUNC_READ) begin
                  cmd.rd_index = (req_port_sel == PORT_INDEX);
                  cmd.rd_reg   = (req_port_sel == PORT_DATA);
               end else if (req_port_sel == PORT_DATA) begin
                  cmd.wr_reg = 1'b1;
               end else if (status.lock_byte) begin
                  cmd.lock = 1'b1;
                  state_in = ST_LOCKED;
               end else begin
                  cmd.wr_index = 1'b1;
               end
            end
            default: begin
               state_in = ST_LOCKED;
            end
         endcase
      end
      cmd.unlocked = (state_in == ST_UNLOCKED);
   end

endmodule

@@ design/sio_datapath.sv @@
`timescale 1ns / 1ps
module sio_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [7:0]              csr_wdata,
   input  sio_pkg::sio_cmd_type    cmd,
   input  logic [7:0]              write_data,
   output sio_pkg::sio_status_type status,
   output logic [7:0]              read_data,
   output logic                    regs_unlocked,
   output logic                    fdc_port_enable,
   output logic                    reconfig_valid,
   output logic [1:0]              reconfig_device,
   output logic                    reconfig_enabled,
   output logic [15:0]             reconfig_base,
   output logic [7:0]              reconfig_irq
);
   import sio_pkg::*;

   logic [7:0]  key_ff;
   logic [7:0]  hist0_ff, hist1_ff;
   logic [7:0]  index_ff;
   logic [3:0]  sel_ff;
   logic        fdc_ff, fdc_in;
   logic [7:0]  dev_enable_ff [NUM_DEVICES];
   logic [15:0] dev_base_ff   [NUM_DEVICES];
   logic [7:0]  dev_irq_ff    [NUM_DEVICES];
   logic [7:0]  dev_dma_ff    [NUM_DEVICES];

   logic [7:0]  read_data_ff, read_data_in;
   logic        unlocked_ff;
   logic        ev_ff, ev_in;
   logic [1:0]  dev_ff, dev_in;
   logic        en_bit_ff, en_bit_in;
   logic [15:0] base_ff, base_in;
   logic [7:0]  irq_ff, irq_in;

   logic [DEV_W-1:0] dev_idx;
   logic             dev_ok;
   logic             wr_dev;
   logic [7:0]       cur_en, cur_irq, cur_dma, new_en, new_irq, reg_rd;
   logic [15:0]      cur_base, new_base;

   assign status.lock_byte = (write_data == LOCK_BYTE);
   assign status.key_hit   = (write_data == key_ff) && (hist0_ff == key_ff);

   assign dev_idx = sel_ff[DEV_W-1:0];
   assign dev_ok  = ({1'b0, sel_ff} < 5'(NUM_DEVICES));
   assign wr_dev  = cmd.wr_reg && (index_ff != REG_SEL) && dev_ok;

   assign cur_en   = dev_ok ? dev_enable_ff[dev_idx] : 8'h00;
   assign cur_base = dev_ok ? dev_base_ff[dev_idx]   : 16'h0000;
   assign cur_irq  = dev_ok ? dev_irq_ff[dev_idx]    : 8'h00;
   assign cur_dma  = dev_ok ? dev_dma_ff[dev_idx]    : 8'h00;

   // per-device values as they stand after this beat's write
   always_comb begin
      new_en   = cur_en;
      new_base = cur_base;
      new_irq  = cur_irq;
      if (wr_dev) begin
         case (index_ff)
            REG_EN:  new_en   = write_data;
            REG_BHI: new_base = {write_data, cur_base[7:0]};
            REG_BLO: new_base = {cur_base[15:8], write_data};
            REG_IRQ: new_irq  = write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index_ff)
         REG_SEL: reg_rd = {4'h0, sel_ff};
         REG_ID:  reg_rd = ID_VALUE;
         REG_REV: reg_rd = REV_VALUE;
         REG_EN:  reg_rd = cur_en;
         REG_BHI: reg_rd = cur_base[15:8];
         REG_BLO: reg_rd = cur_base[7:0];
         REG_IRQ: reg_rd = cur_irq;
         REG_DMA: reg_rd = cur_dma;
         default: reg_rd = UNKNOWN_READ;
      endcase
   end

   always_comb begin
      read_data_in = cmd.rd_index ? index_ff : (cmd.rd_reg ? reg_rd : UNKNOWN_READ);
      ev_in        = cmd.wr_reg && (index_ff != REG_SEL) && (sel_ff <= DEV_LAST_REMAP);
      dev_in       = ev_in ? sel_ff[1:0] : 2'd0;
      en_bit_in    = ev_in && new_en[0];
      base_in      = ev_in ? new_base : 16'h0000;
      irq_in       = ev_in ? new_irq : 8'h00;
      fdc_in       = cmd.lock ? 1'b1 : (cmd.unlock ? 1'b0 : fdc_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff      <= KEY_RESET;
         hist0_ff    <= 8'h00;
         hist1_ff    <= 8'h00;
         index_ff    <= 8'h00;
         sel_ff      <= 4'h0;
         fdc_ff      <= 1'b1;
         unlocked_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            key_ff <= csr_wdata;
         end
         if (cmd.wr_key) begin
            hist1_ff <= hist0_ff;
            hist0_ff <= write_data;
         end
         if (cmd.wr_index) begin
            index_ff <= write_data;
         end
         if (cmd.wr_reg && index_ff == REG_SEL) begin
            sel_ff <= write_data[3:0];
         end
         fdc_ff <= fdc_in;
         if (cmd.load) begin
            unlocked_ff <= cmd.unlocked;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_DEVICES; i++) begin
         if (reset) begin
            dev_enable_ff[i] <= 8'h00;
            dev_base_ff[i]   <= 16'h0000;
            dev_irq_ff[i]    <= 8'h00;
            dev_dma_ff[i]    <= 8'h00;
         end else if (wr_dev && dev_idx == DEV_W'(i)) begin
            case (index_ff)
               REG_EN:  dev_enable_ff[i] <= write_data;
               REG_BHI: dev_base_ff[i]   <= {write_data, dev_base_ff[i][7:0]};
               REG_BLO: dev_base_ff[i]   <= {dev_base_ff[i][15:8], write_data};
               REG_IRQ: dev_irq_ff[i]    <= write_data;
               REG_DMA: dev_dma_ff[i]    <= write_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         read_data_ff <= read_data_in;
         ev_ff        <= ev_in;
         dev_ff       <= dev_in;
         en_bit_ff    <= en_bit_in;
         base_ff      <= base_in;
         irq_ff       <= irq_in;
      end
   end

   assign read_data        = read_data_ff;
   assign regs_unlocked    = unlocked_ff;
   assign fdc_port_enable  = fdc_ff;
   assign reconfig_valid   = ev_ff;
   assign reconfig_device  = dev_ff;
   assign reconfig_enabled = en_bit_ff;
   assign reconfig_base    = base_ff;
   assign reconfig_irq     = irq_ff;

endmodule

@@ design/superio_config_register_port.sv @@
`timescale 1ns / 1ps
// The response beat is valid in the cycle after the request beat is taken.
// Throughput: one beat per cycle; a request is taken whenever the response
// register is empty or being drained in the same cycle.
// Reset (synchronous, active high): port locked, FDC port enable set, unlock key
// 0x87, index, device select, key history and all per-device registers cleared.
module superio_config_register_port (
   input  logic       clock,
   input  logic       reset,
   sio_req_if.sink    req_bus,
   sio_rsp_if.source  rsp_bus,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata
);
   import sio_pkg::*;

   sio_cmd_type    cmd;
   sio_status_type status;

   sio_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_bus.valid),
      .req_func     (req_bus.func),
      .req_port_sel (req_bus.port_sel),
      .req_ready    (req_bus.ready),
      .rsp_valid    (rsp_bus.valid),
      .rsp_ready    (rsp_bus.ready),
      .status       (status),
      .cmd          (cmd)
   );

   sio_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .write_data       (req_bus.write_data),
      .status           (status),
      .read_data        (rsp_bus.read_data),
      .regs_unlocked    (rsp_bus.regs_unlocked),
      .fdc_port_enable  (rsp_bus.fdc_port_enable),
      .reconfig_valid   (rsp_bus.reconfig_valid),
      .reconfig_device  (rsp_bus.reconfig_device),
      .reconfig_enabled (rsp_bus.reconfig_enabled),
      .reconfig_base    (rsp_bus.reconfig_base),
      .reconfig_irq     (rsp_bus.reconfig_irq)
   );

endmodule

@@ design/sio_checker.sv @@
`timescale 1ns / 1ps
module sio_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  read_data,
   input logic        regs_unlocked,
   input logic        fdc_port_enable,
   input logic        reconfig_valid,
   input logic [1:0]  reconfig_device,
   input logic [15:0] reconfig_base,
   input logic [7:0]  reconfig_irq
);
   import sio_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_fdc_off_unlocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && regs_unlocked |-> !fdc_port_enable)
      else $error("FDC port enabled while unlocked");

   a_locked_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !regs_unlocked |-> !reconfig_valid && read_data == UNKNOWN_READ)
      else $error("locked beat returned data or remap event");

   a_no_event_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !reconfig_valid |->
         reconfig_device == 2'd0 && reconfig_base == 16'h0000 && reconfig_irq == 8'h00)
      else $error("remap fields nonzero without event");

endmodule

bind superio_config_register_port sio_checker u_sio_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .read_data       (rsp_bus.read_data),
   .regs_unlocked   (rsp_bus.regs_unlocked),
   .fdc_port_enable (rsp_bus.fdc_port_enable),
   .reconfig_valid  (rsp_bus.reconfig_valid),
   .reconfig_device (rsp_bus.reconfig_device),
   .reconfig_base   (rsp_bus.reconfig_base),
   .reconfig_irq    (rsp_bus.reconfig_irq)
);
